// ===== hdl/pcq_pkg.sv =====
// Shared types, codes and constants of the page cache tag engine.
`default_nettype none
package pcq_pkg;

   localparam int PCQ_ENTRIES = 16;

   localparam int PCQ_ENTRY_W   = 4;
   localparam int PCQ_CSR_IDX_W = 4;
   localparam int PCQ_CSR_DAT_W = 17;

   localparam logic [16:0] FRAME_BYTES_RST = 17'd256;
   localparam logic [4:0]  OWNER_QUOTA_RST = 5'd4;

   // configuration register indexes
   localparam logic [PCQ_CSR_IDX_W-1:0] CSR_FRAME_BYTES = 4'd0;
   localparam logic [PCQ_CSR_IDX_W-1:0] CSR_OWNER_QUOTA = 4'd1;

   // operation codes
   localparam logic [1:0] OP_ACCESS  = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_FLUSH   = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] pid;
      logic [15:0] page;
      logic [15:0] offset;
      logic [16:0] length;
   } req_type;

   typedef struct packed {
      logic        status;
      logic        hit;
      logic [3:0]  entry;
      logic        evicted;
      logic [15:0] evicted_pid;
      logic [15:0] evicted_page;
   } rsp_type;

   typedef struct packed {
      logic [15:0] owner;
      logic [15:0] page;
      logic [31:0] stamp;
   } tag_type;

   typedef struct packed {
      logic owner_match;
      logic hit;
      logic own_found;
      logic free_found;
   } scan_flags_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_WRITE,
      ST_RESP
   } pcq_state_type;

endpackage
`default_nettype wire

// ===== hdl/pcq_tag_ram.sv =====
// Tag store: owner, page and age stamp per entry, one write and one registered read port.
`default_nettype none
module pcq_tag_ram
   import pcq_pkg::*;
#(
   parameter int DEPTH  = PCQ_ENTRIES,
   parameter int ADDR_W = $clog2(PCQ_ENTRIES)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire tag_type           wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output tag_type                rd_data
);

   tag_type mem_ff [DEPTH];
   tag_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hdl/pcq_scan_unit.sv =====
// Per-entry compare unit: one entry a cycle for hit, owner count, free slot and oldest stamps.
`default_nettype none
module pcq_scan_unit
   import pcq_pkg::*;
#(
   parameter int IDX_W   = $clog2(PCQ_ENTRIES),
   parameter int CNT_W   = $clog2(PCQ_ENTRIES + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             clr,
   input  wire logic             step,
   input  wire logic [IDX_W-1:0] idx,
   input  wire logic             ent_valid,
   input  wire tag_type          tag,
   input  wire logic [15:0]      pid,
   input  wire logic [15:0]      page,
   output scan_flags_type        flags,
   output logic [IDX_W-1:0]      hit_idx,
   output logic [CNT_W-1:0]      held,
   output logic [IDX_W-1:0]      own_idx,
   output logic [15:0]           own_page,
   output logic [IDX_W-1:0]      free_idx,
   output logic [IDX_W-1:0]      glob_idx,
   output logic [15:0]           glob_owner,
   output logic [15:0]           glob_page
);

   logic             hit_ff, hit_in;
   logic             own_found_ff, own_found_in;
   logic             free_found_ff, free_found_in;
   logic             glob_found_ff, glob_found_in;
   logic [CNT_W-1:0] held_ff, held_in;
   logic [IDX_W-1:0] hit_idx_ff, own_idx_ff, free_idx_ff, glob_idx_ff;
   logic [31:0]      own_stamp_ff, glob_stamp_ff;
   logic [15:0]      own_page_ff, glob_owner_ff, glob_page_ff;

   logic owner_eq, page_eq, take_hit, take_own, take_free, take_glob;

   assign owner_eq = (tag.owner == pid);
   assign page_eq  = (tag.page == page);

   always_comb begin
      take_hit  = step && ent_valid && owner_eq && page_eq && !hit_ff;
      take_own  = step && ent_valid && owner_eq &&
                  (!own_found_ff || (tag.stamp < own_stamp_ff));
      // strict compare keeps the lower index on equal stamps
      take_glob = step && ent_valid && (!glob_found_ff || (tag.stamp < glob_stamp_ff));
      take_free = step && !ent_valid && !free_found_ff;

      hit_in        = hit_ff;
      own_found_in  = own_found_ff;
      free_found_in = free_found_ff;
      glob_found_in = glob_found_ff;
      held_in       = held_ff;
      if (clr) begin
         hit_in        = 1'b0;
         own_found_in  = 1'b0;
         free_found_in = 1'b0;
         glob_found_in = 1'b0;
         held_in       = '0;
      end else begin
         if (take_hit)  hit_in        = 1'b1;
         if (take_own)  own_found_in  = 1'b1;
         if (take_free) free_found_in = 1'b1;
         if (take_glob) glob_found_in = 1'b1;
         if (step && ent_valid && owner_eq) held_in = held_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff        <= 1'b0;
         own_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         glob_found_ff <= 1'b0;
         held_ff       <= '0;
      end else begin
         hit_ff        <= hit_in;
         own_found_ff  <= own_found_in;
         free_found_ff <= free_found_in;
         glob_found_ff <= glob_found_in;
         held_ff       <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_hit) begin
         hit_idx_ff <= idx;
      end
      if (take_own) begin
         own_idx_ff   <= idx;
         own_stamp_ff <= tag.stamp;
         own_page_ff  <= tag.page;
      end
      if (take_free) begin
         free_idx_ff <= idx;
      end
      if (take_glob) begin
         glob_idx_ff   <= idx;
         glob_stamp_ff <= tag.stamp;
         glob_owner_ff <= tag.owner;
         glob_page_ff  <= tag.page;
      end
   end

   assign flags.owner_match = owner_eq;
   assign flags.hit         = hit_ff;
   assign flags.own_found   = own_found_ff;
   assign flags.free_found  = free_found_ff;
   assign hit_idx    = hit_idx_ff;
   assign held       = held_ff;
   assign own_idx    = own_idx_ff;
   assign own_page   = own_page_ff;
   assign free_idx   = free_idx_ff;
   assign glob_idx   = glob_idx_ff;
   assign glob_owner = glob_owner_ff;
   assign glob_page  = glob_page_ff;

endmodule
`default_nettype wire

// ===== hdl/page_cache_quota_lru_tags_unit.sv =====
// Top level of the page cache tag engine: sequencer, valid bits, access clock and ports.
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_ready   req_data  (req_type)
//   rsp_      out        rsp_valid / rsp_ready   rsp_data  (rsp_type)
//   csr_      in         csr_valid / csr_ready   csr_index, csr_wdata
//
// An access passes the check, scan, write and response states before rsp_valid
// rises, a release check, scan and response; flush, refused accesses and unused
// codes skip the scan, where the read port feeds the compare one entry a cycle.
// req_ready returns the cycle after the result is loaded.
// Reset clears all valid bits at once; no clearing pass. The result sits in
// an output register, so a stalled rsp_ channel holds only the following item.
`default_nettype none
module page_cache_quota_lru_tags_unit
   import pcq_pkg::*;
#(
   parameter int NUM_ENTRIES = PCQ_ENTRIES
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire req_type                  req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output rsp_type                       rsp_data,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [PCQ_CSR_IDX_W-1:0] csr_index,
   input  wire logic [PCQ_CSR_DAT_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(NUM_ENTRIES);
   localparam int CNT_W = $clog2(NUM_ENTRIES + 1);
   localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_ENTRIES);

   pcq_state_type state_ff, state_in;

   req_type                  req_ff;
   rsp_type                  res_ff, rsp_data_ff, write_res, check_res;
   logic                     rsp_valid_ff;
   logic [16:0]              frame_bytes_ff;
   logic [4:0]               owner_quota_ff;
   logic [NUM_ENTRIES-1:0]   valid_ff;
   logic [31:0]              access_clock_ff, clock_next;
   logic [CNT_W-1:0]         rd_cnt_ff;
   logic                     dv_ff;
   logic [IDX_W-1:0]         didx_ff;

   logic scan_clr, rd_en, rsp_load;
   logic bounds_err, quota_full, scan_done;
   logic [17:0] end_sum;
   logic [IDX_W-1:0] victim;

   tag_type          rd_tag, wr_tag;
   scan_flags_type   flags;
   logic [IDX_W-1:0] hit_idx, own_idx, free_idx, glob_idx;
   logic [CNT_W-1:0] held;
   logic [15:0]      own_page, glob_owner, glob_page;

   pcq_tag_ram #(
      .DEPTH  (NUM_ENTRIES),
      .ADDR_W (IDX_W)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (state_ff == ST_WRITE),
      .wr_addr (victim),
      .wr_data (wr_tag),
      .rd_en   (rd_en),
      .rd_addr (rd_cnt_ff[IDX_W-1:0]),
      .rd_data (rd_tag)
   );

   pcq_scan_unit #(
      .IDX_W   (IDX_W),
      .CNT_W   (CNT_W)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .clr        (scan_clr),
      .step       (dv_ff),
      .idx        (didx_ff),
      .ent_valid  (valid_ff[didx_ff]),
      .tag        (rd_tag),
      .pid        (req_ff.pid),
      .page       (req_ff.page),
      .flags      (flags),
      .hit_idx    (hit_idx),
      .held       (held),
      .own_idx    (own_idx),
      .own_page   (own_page),
      .free_idx   (free_idx),
      .glob_idx   (glob_idx),
      .glob_owner (glob_owner),
      .glob_page  (glob_page)
   );

   assign end_sum      = 18'(req_ff.offset) + 18'(req_ff.length);
   assign bounds_err   = (17'(req_ff.offset) >= frame_bytes_ff) ||
                         (end_sum > 18'(frame_bytes_ff));
   assign scan_done    = (rd_cnt_ff == LAST_CNT) && !dv_ff;
   assign clock_next   = (access_clock_ff == '1) ? access_clock_ff : access_clock_ff + 32'd1;
   assign quota_full   = (held != '0) && (CMP_W'(held) >= CMP_W'(owner_quota_ff));

   // result of the bounds check stage
   always_comb begin
      check_res        = '0;
      check_res.status = (req_ff.op == OP_ACCESS) && bounds_err;
   end

   // victim choice and result of an access
   always_comb begin
      write_res = '0;
      victim    = glob_idx;
      if (flags.hit) begin
         victim        = hit_idx;
         write_res.hit = 1'b1;
      end else if (quota_full && flags.own_found) begin
         victim                 = own_idx;
         write_res.evicted      = 1'b1;
         write_res.evicted_pid  = req_ff.pid;
         write_res.evicted_page = own_page;
      end else if (flags.free_found) begin
         victim = free_idx;
      end else begin
         write_res.evicted      = 1'b1;
         write_res.evicted_pid  = glob_owner;
         write_res.evicted_page = glob_page;
      end
      write_res.entry = PCQ_ENTRY_W'(victim);
   end

   assign wr_tag.owner = req_ff.pid;
   assign wr_tag.page  = req_ff.page;
   assign wr_tag.stamp = clock_next;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            case (req_ff.op)
               OP_ACCESS:  state_in = bounds_err ? ST_RESP : ST_SCAN;
               OP_RELEASE: state_in = ST_SCAN;
               default:    state_in = ST_RESP;
            endcase
         end
         ST_SCAN: begin
            if (scan_done) state_in = (req_ff.op == OP_ACCESS) ? ST_WRITE : ST_RESP;
         end
         ST_WRITE: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state machine outputs
   always_comb begin
      req_ready = 1'b0;
      scan_clr  = 1'b0;
      rd_en     = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_CHECK: scan_clr  = 1'b1;
         ST_SCAN:  rd_en     = (rd_cnt_ff != LAST_CNT);
         ST_RESP:  rsp_load  = !rsp_valid_ff || rsp_ready;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         frame_bytes_ff  <= FRAME_BYTES_RST;
         owner_quota_ff  <= OWNER_QUOTA_RST;
         valid_ff        <= '0;
         access_clock_ff <= '0;
         rd_cnt_ff       <= '0;
         dv_ff           <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         dv_ff    <= rd_en;

         if (csr_valid) begin
            case (csr_index)
               CSR_FRAME_BYTES: frame_bytes_ff <= csr_wdata;
               CSR_OWNER_QUOTA: owner_quota_ff <= csr_wdata[4:0];
               default: begin
               end
            endcase
         end

         if (state_ff == ST_CHECK) begin
            rd_cnt_ff <= '0;
            if (req_ff.op == OP_FLUSH) valid_ff <= '0;
         end else if (rd_en) begin
            rd_cnt_ff <= rd_cnt_ff + 1'b1;
         end

         if (state_ff == ST_SCAN && dv_ff && req_ff.op == OP_RELEASE &&
             flags.owner_match) begin
            valid_ff[didx_ff] <= 1'b0;
         end

         if (state_ff == ST_WRITE) begin
            valid_ff[victim] <= 1'b1;
            access_clock_ff  <= clock_next;
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      didx_ff <= rd_cnt_ff[IDX_W-1:0];
      if (state_ff == ST_CHECK) begin
         res_ff <= check_res;
      end else if (state_ff == ST_WRITE) begin
         res_ff <= write_res;
      end
      if (rsp_load) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && req_ff.op == OP_FLUSH) |=> (valid_ff == '0))
      else $error("flush left a valid entry");

   a_victim_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |=> valid_ff[$past(victim)])
      else $error("used entry not marked valid");

   a_clock_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (access_clock_ff >= $past(access_clock_ff)))
      else $error("access clock went backward");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.hit && rsp_data_ff.evicted) &&
                       !(rsp_data_ff.status && rsp_data_ff.hit))
      else $error("inconsistent result flags");

endmodule
`default_nettype wire
